### rtl/samd_pkg.sv
package samd_pkg;

  localparam int CtlW      = 12;
  localparam int DataW     = 8;
  localparam int MplrW     = 7;
  localparam int AccW      = 14;
  localparam int CtrW      = 4;
  localparam int InTdataW  = 24;
  localparam int OutTdataW = 24;

  localparam logic [CtrW-1:0] CtrLoadVal = CtrW'(2);

  localparam int CTL_CTR_LOAD   = 0;
  localparam int CTL_CTR_INC    = 1;
  localparam int CTL_MPLR_LOAD  = 2;
  localparam int CTL_MPLR_SHL   = 3;
  localparam int CTL_MCAND_LOAD = 4;
  localparam int CTL_ACC_CLR    = 5;
  localparam int CTL_ACC_ADD    = 6;
  localparam int CTL_ACC_SHL    = 7;
  localparam int CTL_T1         = 8;
  localparam int CTL_T2         = 9;
  localparam int CTL_BUS1       = 10;
  localparam int CTL_BUS2       = 11;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_CTR       = 3'd1,
    ERR_MPLR      = 3'd2,
    ERR_MCAND     = 3'd3,
    ERR_ACC       = 3'd4,
    ERR_EMPTY_BUS = 3'd5
  } err_t;

  // data_out sits in the low bits
  typedef struct packed {
    err_t        error_code;
    logic        result_sign;
    logic        acc_nonzero;
    logic        signs_differ;
    logic        multiplier_msb;
    logic        counter_done;
    logic [1:0]  out_count;
    logic [DataW-1:0] data_out;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage

### rtl/samd_core.sv
module samd_core
  import samd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [CtlW-1:0]  ctl,
  input  logic [DataW-1:0] data,
  input  logic             data_valid,
  output result_t          res
);

  logic [MplrW-1:0] mplr_r, mplr_nxt;
  logic [MplrW-1:0] mcand_r, mcand_nxt;
  logic [AccW-1:0]  acc_r, acc_nxt;
  logic [CtrW-1:0]  ctr_r, ctr_nxt;
  logic             sign_a_r, sign_a_nxt;
  logic             sign_b_r, sign_b_nxt;

  err_t       err;
  logic [1:0] acc_ops;
  logic       differ, nonzero, rsign, upd;

  always_comb begin
    differ  = sign_a_r ^ sign_b_r;
    nonzero = |acc_r;
    rsign   = differ & nonzero;
    acc_ops = 2'(ctl[CTL_ACC_CLR]) + 2'(ctl[CTL_ACC_ADD]) + 2'(ctl[CTL_ACC_SHL]);

    if (ctl[CTL_CTR_LOAD] && ctl[CTL_CTR_INC]) begin
      err = ERR_CTR;
    end else if (ctl[CTL_MPLR_LOAD] && ctl[CTL_MPLR_SHL]) begin
      err = ERR_MPLR;
    end else if (acc_ops > 2'd1) begin
      err = ERR_ACC;
    end else if (!data_valid && ctl[CTL_MPLR_LOAD] && ctl[CTL_MCAND_LOAD] &&
                 ctl[CTL_T1] && ctl[CTL_T2]) begin
      err = ERR_EMPTY_BUS;
    end else begin
      err = ERR_OK;
    end

    if (ctl[CTL_BUS1]) begin
      res.data_out = {rsign, 1'b0, acc_r[AccW-1:8]};
    end else if (ctl[CTL_BUS2]) begin
      res.data_out = acc_r[7:0];
    end else begin
      res.data_out = '0;
    end
    res.out_count      = 2'(ctl[CTL_BUS1]) + 2'(ctl[CTL_BUS2]);
    res.counter_done   = ctr_r[3];
    res.multiplier_msb = mplr_r[MplrW-1];
    res.signs_differ   = differ;
    res.acc_nonzero    = nonzero;
    res.result_sign    = rsign;
    res.error_code     = err;

    upd        = step_en && (err == ERR_OK);
    ctr_nxt    = ctr_r;
    mplr_nxt   = mplr_r;
    mcand_nxt  = mcand_r;
    acc_nxt    = acc_r;
    sign_a_nxt = sign_a_r;
    sign_b_nxt = sign_b_r;
    if (upd) begin
      if (ctl[CTL_CTR_LOAD]) begin
        ctr_nxt = CtrLoadVal;
      end else if (ctl[CTL_CTR_INC]) begin
        ctr_nxt = ctr_r + CtrW'(1);
      end
      if (ctl[CTL_MPLR_LOAD]) begin
        mplr_nxt = data[MplrW-1:0];
      end else if (ctl[CTL_MPLR_SHL]) begin
        mplr_nxt = {mplr_r[MplrW-2:0], 1'b0};
      end
      if (ctl[CTL_MCAND_LOAD]) begin
        mcand_nxt = data[MplrW-1:0];
      end
      if (ctl[CTL_ACC_CLR]) begin
        acc_nxt = '0;
      end else if (ctl[CTL_ACC_ADD]) begin
        acc_nxt = acc_r + AccW'(mcand_r);
      end else if (ctl[CTL_ACC_SHL]) begin
        acc_nxt = {acc_r[AccW-2:0], 1'b0};
      end
      if (ctl[CTL_T1]) begin
        sign_a_nxt = data[DataW-1];
      end
      if (ctl[CTL_T2]) begin
        sign_b_nxt = data[DataW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mplr_r   <= '0;
      mcand_r  <= '0;
      acc_r    <= '0;
      ctr_r    <= '0;
      sign_a_r <= 1'b0;
      sign_b_r <= 1'b0;
    end else begin
      mplr_r   <= mplr_nxt;
      mcand_r  <= mcand_nxt;
      acc_r    <= acc_nxt;
      ctr_r    <= ctr_nxt;
      sign_a_r <= sign_a_nxt;
      sign_b_r <= sign_b_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (err != ERR_OK) |=>
      $stable(acc_r) && $stable(mplr_r) && $stable(mcand_r) && $stable(ctr_r))
    else $error("state changed on a faulted beat");
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(acc_r) && $stable(ctr_r) && $stable(sign_a_r) &&
      $stable(sign_b_r))
    else $error("state changed with no beat");
  a_no_mcand_err: assert property (@(posedge clk) disable iff (!rst_n)
    err != ERR_MCAND)
    else $error("multiplicand conflict raised");
`endif

endmodule

### rtl/shift_add_multiplier_datapath_core.sv
// Datapath of a 7-bit sign-magnitude shift-add multiplier. Each input beat
// carries one control word plus a data byte and produces exactly one output
// beat holding the status flags and bus byte seen before the beat's update,
// and an error code; a beat with a nonzero error code changes no state.
// One beat is taken every clock unless both registers hold beats and
// out_tready is low; an accepted beat passes through the input register,
// then the result register, written as the shared state updates.
// Back-pressure on out_tready reaches in_tready combinationally through the two-register pipe.
module shift_add_multiplier_datapath_core
  import samd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,   // control[11:0], data_in[19:12], zero pad
  input  logic                 in_tuser,   // data_valid
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutTdataW-1:0] out_tdata   // data_out[7:0], out_count[9:8],
                                           // counter_done[10], multiplier_msb[11],
                                           // signs_differ[12], acc_nonzero[13],
                                           // result_sign[14], error_code[17:15], pad
);

  logic             v1_r, v1_nxt;
  logic             v2_r, v2_nxt;
  logic [CtlW-1:0]  ctl_r, ctl_nxt;
  logic [DataW-1:0] data_r, data_nxt;
  logic             dvalid_r, dvalid_nxt;
  result_t          res_r, res_nxt;
  result_t          res;
  logic             in_acc, adv;

  assign adv       = v1_r && (!v2_r || out_tready);
  assign in_tready = !v1_r || !v2_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  samd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .ctl        (ctl_r),
    .data       (data_r),
    .data_valid (dvalid_r),
    .res        (res)
  );

  always_comb begin
    ctl_nxt    = in_acc ? in_tdata[CtlW-1:0] : ctl_r;
    data_nxt   = in_acc ? in_tdata[CtlW+DataW-1:CtlW] : data_r;
    dvalid_nxt = in_acc ? in_tuser : dvalid_r;
    v1_nxt     = in_acc ? 1'b1 : (adv ? 1'b0 : v1_r);
    v2_nxt     = adv ? 1'b1 : (out_tready ? 1'b0 : v2_r);
    res_nxt    = adv ? res : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r    <= ctl_nxt;
    data_r   <= data_nxt;
    dvalid_r <= dvalid_nxt;
    res_r    <= res_nxt;
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = {(OutTdataW-ResultW)'(0), res_r};

`ifndef NO_ASSERTIONS
  a_sign_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_r.result_sign == (res_r.signs_differ & res_r.acc_nonzero))
    else $error("result_sign inconsistent");
  a_bus1_gap: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl_r[CTL_BUS1] |=> out_tvalid && (res_r.data_out[6] == 1'b0))
    else $error("bus1 byte bit 6 set");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v1_r && v2_r && !out_tready)
    else $error("input stalled with room in pipe");
`endif

endmodule
